// ----- design/multi_channel_square_wave_generator_unit_macros.svh -----
// assertion macros for the square-wave generator
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef MULTI_CHANNEL_SQUARE_WAVE_GENERATOR_UNIT_MACROS_SVH
`define MULTI_CHANNEL_SQUARE_WAVE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define MSW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msw assertion failed");

// next-cycle implication
`define MSW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msw assertion failed");

`endif

// ----- design/msw_pkg.sv -----
// shared types and constants of the square-wave generator
// no dependencies
`default_nettype none

package msw_pkg;

  localparam int OP_W   = 2;
  localparam int CH_W   = 4;
  localparam int FREQ_W = 16;
  localparam int HP_W   = 9;
  localparam int OUT_W  = 12;
  localparam int DIVD_W = 11;
  localparam int DIVS_W = 10;

  localparam logic [FREQ_W-1:0] FREQ_MAX  = 16'd500;
  localparam logic [DIVD_W-1:0] DIVD_BASE = 11'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_STOP = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic div_start;
    logic hp_write;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic fzero;
    logic div_done;
    logic scan_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/multi_channel_square_wave_generator_unit.sv -----
// channel   ports                                         width
// input     in_valid in_stall in_opcode in_channel in_freq_hz  2/4/16
// result    out_valid out_stall out_levels out_toggled    12/12
//
// one item at a time; a tick passes through the decode, scan and result states,
// set with nonzero frequency through decode, the 11-step serial divider and result, other items decode and result
// the tick scan visits one channel per cycle through the phase and half-period registers
// reset clears all half-periods, phases and levels at once; no clearing pass
// a held result waits in the output register while the next item is accepted
// top level: joins controller and datapath; depends on msw_pkg, msw_ctrl, msw_dp
`default_nettype none

module multi_channel_square_wave_generator_unit #(
  parameter int CHANNELS = 12
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [msw_pkg::OP_W-1:0]   in_opcode,
  input  wire [msw_pkg::CH_W-1:0]   in_channel,
  input  wire [msw_pkg::FREQ_W-1:0] in_freq_hz,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic [msw_pkg::OUT_W-1:0] out_levels,
  output logic [msw_pkg::OUT_W-1:0] out_toggled
);
  import msw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  msw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  msw_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_opcode   (in_opcode),
    .in_channel  (in_channel),
    .in_freq_hz  (in_freq_hz),
    .out_levels  (out_levels),
    .out_toggled (out_toggled)
  );

endmodule

`default_nettype wire

// ----- design/msw_div.sv -----
// restoring divider for the half-period, one quotient bit per cycle
// depends on msw_pkg
`default_nettype none

module msw_div (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [msw_pkg::DIVD_W-1:0] dividend,
  input  wire [msw_pkg::DIVS_W-1:0] divisor,
  output logic                      busy,
  output logic [msw_pkg::HP_W-1:0]  quotient
);
  import msw_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DIVD_W-1:0] trial;
  logic              fits;

  always_comb begin
    trial    = {rem_r[DIVD_W-2:0], quo_r[DIVD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DIVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt  = {quo_r[DIVD_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r[HP_W-1:0];

endmodule

`default_nettype wire

// ----- design/msw_dp.sv -----
// datapath: captured item, per-channel half-period and phase, levels, result registers
// depends on msw_pkg and msw_div
`default_nettype none

module msw_dp #(
  parameter int CHANNELS = 12
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire msw_pkg::cmd_t        cmd,
  output msw_pkg::sts_t             sts,
  input  wire [msw_pkg::OP_W-1:0]   in_opcode,
  input  wire [msw_pkg::CH_W-1:0]   in_channel,
  input  wire [msw_pkg::FREQ_W-1:0] in_freq_hz,
  output logic [msw_pkg::OUT_W-1:0] out_levels,
  output logic [msw_pkg::OUT_W-1:0] out_toggled
);
  import msw_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  op_t             op_r;
  logic [CW-1:0]   idx_r;
  logic            ch_ok_r;
  logic [HP_W-1:0] f_r;
  logic [CW-1:0]   sc_r;

  logic [HP_W-1:0]     hp_r [CHANNELS];
  logic [HP_W-1:0]     ph_r [CHANNELS];
  logic [CHANNELS-1:0] level_r;
  logic [CHANNELS-1:0] flips_r;
  logic [OUT_W-1:0]    lev_out_r, tog_out_r;

  logic                div_busy;
  logic [HP_W-1:0]     quo;
  logic [HP_W-1:0]     hp_sc, ph_inc;
  logic                sc_flip;
  logic [OUT_W-1:0]    lev_vis, tog_vis;

  msw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (DIVD_BASE + DIVD_W'(f_r)),
    .divisor  ({f_r, 1'b0}),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign hp_sc   = hp_r[sc_r];
  assign ph_inc  = ph_r[sc_r] + 1'b1;
  assign sc_flip = (hp_sc != '0) && (ph_inc >= hp_sc);

  for (genvar g = 0; g < OUT_W; g++) begin : g_vis
    if (g < CHANNELS) begin : g_on
      assign lev_vis[g] = level_r[g];
      assign tog_vis[g] = flips_r[g];
    end else begin : g_off
      assign lev_vis[g] = 1'b0;
      assign tog_vis[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= op_t'(in_opcode);
      idx_r   <= CW'(in_channel);
      ch_ok_r <= (32'(in_channel) < CHANNELS);
      f_r     <= (in_freq_hz > FREQ_MAX) ? HP_W'(FREQ_MAX) : in_freq_hz[HP_W-1:0];
    end
    if (cmd.out_load) begin
      lev_out_r <= lev_vis;
      tog_out_r <= tog_vis;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hp_r[i] <= '0;
        ph_r[i] <= '0;
      end
      level_r <= '0;
      flips_r <= '0;
      sc_r    <= '0;
    end else begin
      if (cmd.load) begin
        flips_r <= '0;
        sc_r    <= '0;
      end
      if (cmd.apply && ch_ok_r) begin
        unique case (op_r)
          OP_SET: begin
            if (f_r == '0) hp_r[idx_r] <= '0;
          end
          OP_STOP: begin
            hp_r[idx_r]    <= '0;
            level_r[idx_r] <= 1'b0;
          end
          OP_TICK, OP_NONE: ;
          default: ;
        endcase
      end
      if (cmd.hp_write && ch_ok_r) begin
        hp_r[idx_r] <= quo;
        ph_r[idx_r] <= '0;
      end
      if (cmd.scan_step) begin
        if (hp_sc != '0) ph_r[sc_r] <= sc_flip ? '0 : ph_inc;
        if (sc_flip) begin
          level_r[sc_r] <= ~level_r[sc_r];
          flips_r[sc_r] <= 1'b1;
        end
        sc_r <= sc_r + 1'b1;
      end
    end
  end

  assign sts.op        = op_r;
  assign sts.fzero     = (f_r == '0);
  assign sts.div_done  = !div_busy;
  assign sts.scan_last = (sc_r == CW'(CHANNELS - 1));

  assign out_levels  = lev_out_r;
  assign out_toggled = tog_out_r;

endmodule

`default_nettype wire

// ----- design/msw_ctrl.sv -----
// controller: item sequencing state machine and result valid
// depends on msw_pkg and the assertion macro header
`default_nettype none
`include "multi_channel_square_wave_generator_unit_macros.svh"

module msw_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire                out_stall,
  input  wire msw_pkg::sts_t sts,
  output msw_pkg::cmd_t      cmd
);
  import msw_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.op == OP_TICK) begin
          state_nxt = S_SCAN;
        end else if (sts.op == OP_SET && !sts.fzero) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          cmd.apply = 1'b1;
          state_nxt = S_RESULT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.hp_write = 1'b1;
          state_nxt    = S_RESULT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);
  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;

  `MSW_ASSERT_NXT(a_accept_decodes, accept, state_r == S_DECODE && in_stall)
  `MSW_ASSERT_NXT(a_result_shown, cmd.out_load, out_valid_r && state_r == S_IDLE)
  `MSW_ASSERT_NXT(a_scan_runs, state_r == S_SCAN && !sts.scan_last, state_r == S_SCAN)
  `MSW_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_r || !out_stall)

endmodule

`default_nettype wire
